@@ rtl/rtt_pkg.sv @@
// Shared types and constants for the run table range translator.
// Used by rtt_clip and run_table_range_translator; depends on nothing else.
package rtt_pkg;

    localparam int MAX_RUNS  = 16;
    localparam int OFS_W     = 48;
    localparam int OUT_LIMIT = 16;
    localparam int IDX_W     = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
    localparam int CNT_W     = $clog2(MAX_RUNS + 1);
    localparam int NH_W      = $clog2(OUT_LIMIT + 1);

    localparam int IN_DATA_W  = 152;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 112;
    localparam int OUT_USER_W = 2;

    localparam logic [2:0] KIND_APPEND  = 3'd0;
    localparam logic [2:0] KIND_CLEAR   = 3'd1;
    localparam logic [2:0] KIND_INNER   = 3'd2;
    localparam logic [2:0] KIND_MEMBER  = 3'd3;
    localparam logic [2:0] KIND_EXCLUDE = 3'd4;

    typedef struct packed {
        logic [OFS_W-1:0] size;
        logic [OFS_W-1:0] mstart;
        logic [7:0]       member;
        logic [OFS_W-1:0] inner;
    } t_run;

    typedef struct packed {
        logic [OFS_W-1:0] len;
        logic [OFS_W:0]   ofs;
        logic [7:0]       member;
    } t_piece;

endpackage

@@ rtl/rtt_clip.sv @@
// Overlap pipeline: clips one stored run against the query range.
// Two register stages plus a final offset add; depends on rtt_pkg.
module rtt_clip (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_inner,
    input  logic [rtt_pkg::OFS_W-1:0] i_qs,
    input  logic [rtt_pkg::OFS_W:0]   i_qe,
    input  logic [7:0]          i_midx,
    input  logic                i_valid,
    input  rtt_pkg::t_run       i_run,
    output logic                o_busy,
    output logic                o_valid,
    output logic                o_hit,
    output rtt_pkg::t_piece     o_piece
);
    import rtt_pkg::*;

    logic [OFS_W-1:0] rs;
    logic [OFS_W:0]   re;

    logic             r_s1_v;
    logic             r_s1_match;
    logic [OFS_W-1:0] r_s1_from;
    logic [OFS_W:0]   r_s1_to;
    logic [OFS_W-1:0] r_s1_rs;
    logic [OFS_W-1:0] r_s1_other;
    logic [7:0]       r_s1_member;

    logic             r_s2_v;
    logic             r_s2_hit;
    logic [OFS_W-1:0] r_s2_len;
    logic [OFS_W-1:0] r_s2_diff;
    logic [OFS_W-1:0] r_s2_other;
    logic [7:0]       r_s2_member;

    assign rs = i_inner ? i_run.inner : i_run.mstart;
    assign re = {1'b0, rs} + {1'b0, i_run.size};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else if (i_adv) begin
            r_s1_v <= i_valid;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            // Stage 1: intersection bounds.
            r_s1_match  <= i_inner || (i_run.member == i_midx);
            r_s1_from   <= (i_qs > rs) ? i_qs : rs;
            r_s1_to     <= (i_qe < re) ? i_qe : re;
            r_s1_rs     <= rs;
            r_s1_other  <= i_inner ? i_run.mstart : i_run.inner;
            r_s1_member <= i_run.member;
            // Stage 2: overlap size and distance into the run.
            r_s2_hit    <= r_s1_match && ({1'b0, r_s1_from} < r_s1_to);
            r_s2_len    <= OFS_W'(r_s1_to - {1'b0, r_s1_from});
            r_s2_diff   <= r_s1_from - r_s1_rs;
            r_s2_other  <= r_s1_other;
            r_s2_member <= r_s1_member;
        end
    end

    assign o_busy         = r_s1_v || r_s2_v;
    assign o_valid        = r_s2_v;
    assign o_hit          = r_s2_hit;
    assign o_piece.member = r_s2_member;
    assign o_piece.ofs    = {1'b0, r_s2_other} + {1'b0, r_s2_diff};
    assign o_piece.len    = r_s2_len;

endmodule

@@ rtl/run_table_range_translator.sv @@
// Run table range translator top level: run table memory, walk control, output word.
// Depends on rtt_pkg and rtt_clip.
//
// Usage: command words enter on the s_ channel (kind in tuser, run or range in
// tdata); result words leave on the m_ channel, tlast on the final word of each
// command. Append, clear and unknown kinds go from idle to the done state and
// present one word from there. Query and exclude commands walk every stored
// run, one memory read per cycle while the receiver does not stall; a query
// sends each run through a two-stage clip pipeline. Every command ends in the
// done state, which presents the final word. The next command word can be
// taken in the same cycle that the final word is presented.
// A query holds its newest hit back one word so that tlast can be set on the
// true final piece; a query with no overlap gives one word with hit clear. One
// command is worked on at a time: a new word is taken whenever the controller
// is idle, even while the previous result word still waits. When the receiver
// stalls, the walk, the memory read and the clip pipeline freeze together and
// nothing is lost. After reset the table is empty; the run memory itself is
// not cleared and is only read below the run count.
module run_table_range_translator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // tdata: inner_offset[47:0], member_index[55:48], member_offset[103:56], length[151:104]
    input  logic [rtt_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // tuser: kind[2:0]
    input  logic [rtt_pkg::IN_USER_W-1:0]    i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // tdata: piece_member[7:0], piece_offset[56:8], piece_length[104:57],
    //        run_count[109:105], zero pad[111:110]
    output logic [rtt_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    // tuser: hit[0], table_full[1]
    output logic [rtt_pkg::OUT_USER_W-1:0]   o_m_tuser,
    output logic                             o_m_tlast
);
    import rtt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_run             mem [MAX_RUNS];

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_used, n_used;
    logic [CNT_W-1:0] r_ridx, n_ridx;
    logic [CNT_W-1:0] r_wr, n_wr;
    logic [NH_W-1:0]  r_nhits, n_nhits;
    logic             r_pend_v, n_pend_v;
    logic             r_out_v, n_out_v;
    logic             r_rd_v, n_rd_v;

    logic [2:0]       r_kind;
    logic [7:0]       r_midx;
    logic [OFS_W-1:0] r_qs;
    logic [OFS_W:0]   r_qe;
    logic             r_full;
    t_run             r_rd;
    t_piece           r_pend;
    t_piece           r_out;
    logic             r_out_hit;
    logic             r_out_last;
    logic             r_out_full;
    logic [4:0]       r_out_cnt;

    logic [2:0]       in_kind;
    t_run             in_run;
    logic [OFS_W-1:0] in_len;
    logic             adv;
    logic             in_acc;
    logic             is_query;
    logic             issue;
    logic             excl_wr;
    logic             take;
    logic             walk_end;
    logic             table_has_room;
    logic             clip_busy;
    logic             clip_v;
    logic             clip_hit;
    t_piece           clip_piece;

    assign in_kind       = i_s_tuser;
    assign in_run.inner  = i_s_tdata[47:0];
    assign in_run.member = i_s_tdata[55:48];
    assign in_run.mstart = i_s_tdata[103:56];
    assign in_run.size   = i_s_tdata[151:104];
    assign in_len        = i_s_tdata[151:104];

    assign adv            = !r_out_v || i_m_tready;
    assign in_acc         = i_s_tvalid && (r_state == ST_IDLE);
    assign is_query       = (r_kind == KIND_INNER) || (r_kind == KIND_MEMBER);
    assign table_has_room = (r_used < CNT_W'(MAX_RUNS));
    assign issue          = (r_state == ST_WALK) && adv && (r_ridx < r_used);
    assign excl_wr        = adv && r_rd_v && (r_kind == KIND_EXCLUDE)
                            && (r_rd.member != r_midx);
    assign take           = (r_state == ST_WALK) && adv && clip_v && clip_hit && is_query
                            && (r_nhits < NH_W'(OUT_LIMIT));
    assign walk_end       = (r_state == ST_WALK) && (r_ridx == r_used)
                            && !r_rd_v && !clip_busy;

    rtt_clip u_clip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_inner (r_kind == KIND_INNER),
        .i_qs    (r_qs),
        .i_qe    (r_qe),
        .i_midx  (r_midx),
        .i_valid (r_rd_v && is_query),
        .i_run   (r_rd),
        .o_busy  (clip_busy),
        .o_valid (clip_v),
        .o_hit   (clip_hit),
        .o_piece (clip_piece)
    );

    always_comb begin
        n_state  = r_state;
        n_used   = r_used;
        n_ridx   = r_ridx;
        n_wr     = r_wr;
        n_nhits  = r_nhits;
        n_pend_v = r_pend_v;
        n_out_v  = r_out_v;
        n_rd_v   = r_rd_v;
        if (r_out_v && i_m_tready) begin
            n_out_v = 1'b0;
        end
        if (adv) begin
            n_rd_v = issue;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_ridx   = '0;
                    n_wr     = '0;
                    n_nhits  = '0;
                    n_pend_v = 1'b0;
                    if ((in_kind == KIND_INNER) || (in_kind == KIND_MEMBER)
                        || (in_kind == KIND_EXCLUDE)) begin
                        n_state = ST_WALK;
                    end else begin
                        n_state = ST_DONE;
                    end
                    if (in_kind == KIND_CLEAR) begin
                        n_used = '0;
                    end else if ((in_kind == KIND_APPEND) && table_has_room) begin
                        n_used = r_used + 1'b1;
                    end
                end
            end
            ST_WALK: begin
                if (issue) begin
                    n_ridx = r_ridx + 1'b1;
                end
                if (excl_wr) begin
                    n_wr = r_wr + 1'b1;
                end
                if (take) begin
                    n_nhits  = r_nhits + 1'b1;
                    n_pend_v = 1'b1;
                    if (r_pend_v) begin
                        n_out_v = 1'b1;
                    end
                end
                if (walk_end) begin
                    n_state = ST_DONE;
                    if (r_kind == KIND_EXCLUDE) begin
                        n_used = r_wr;
                    end
                end
            end
            ST_DONE: begin
                if (adv) begin
                    n_out_v  = 1'b1;
                    n_pend_v = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_used   <= '0;
            r_ridx   <= '0;
            r_wr     <= '0;
            r_nhits  <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_rd_v   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_ridx   <= n_ridx;
            r_wr     <= n_wr;
            r_nhits  <= n_nhits;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
            r_rd_v   <= n_rd_v;
        end
    end

    // Run memory. Compaction writes land at or below entries already read,
    // so a read never sees an entry that the same walk still has to move.
    always_ff @(posedge i_clk) begin
        if (in_acc && (in_kind == KIND_APPEND) && table_has_room) begin
            mem[r_used[IDX_W-1:0]] <= in_run;
        end else if (excl_wr) begin
            mem[r_wr[IDX_W-1:0]] <= r_rd;
        end
        if (issue) begin
            r_rd <= mem[r_ridx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind <= in_kind;
            r_midx <= in_run.member;
            r_qs   <= (in_kind == KIND_INNER) ? in_run.inner : in_run.mstart;
            r_qe   <= {1'b0, ((in_kind == KIND_INNER) ? in_run.inner : in_run.mstart)}
                      + {1'b0, in_len};
            r_full <= (in_kind == KIND_APPEND) && !table_has_room;
        end
        if (take) begin
            r_pend <= clip_piece;
        end
        if (take && r_pend_v) begin
            r_out      <= r_pend;
            r_out_hit  <= 1'b1;
            r_out_last <= 1'b0;
            r_out_full <= 1'b0;
            r_out_cnt  <= 5'(r_used);
        end else if ((r_state == ST_DONE) && adv) begin
            if (is_query && r_pend_v) begin
                r_out     <= r_pend;
                r_out_hit <= 1'b1;
            end else begin
                r_out     <= '0;
                r_out_hit <= 1'b0;
            end
            r_out_last <= 1'b1;
            r_out_full <= r_full;
            r_out_cnt  <= 5'(r_used);
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {2'b00, r_out_cnt, r_out.len, r_out.ofs, r_out.member};
    assign o_m_tuser  = {r_out_full, r_out_hit};
    assign o_m_tlast  = r_out_last;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(MAX_RUNS))
        else $error("run count exceeds table depth");

    a_compact_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_wr <= r_ridx))
        else $error("compaction write index passed read index");

    a_pend_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (is_query && ((r_state == ST_WALK) || (r_state == ST_DONE))))
        else $error("held piece outside a query");

    a_hit_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nhits <= NH_W'(OUT_LIMIT))
        else $error("piece count above output limit");

endmodule

@@ tb/sv/run_table_range_translator_tb.sv @@
// Self-checking testbench for run_table_range_translator: drives command words, predicts
// every result word with a scoreboard that keeps its own copy of the run table, and
// compares field by field. Depends on rtt_pkg and the block itself.

typedef struct {
    logic        hit;
    logic [7:0]  member;
    logic [48:0] ofs;
    logic [47:0] len;
    logic        last;
    logic [4:0]  count;
    logic        full;
} xlat_word_t;

class xlat_scoreboard;
    logic [47:0] inner_tab  [rtt_pkg::MAX_RUNS];
    logic [7:0]  member_tab [rtt_pkg::MAX_RUNS];
    logic [47:0] mstart_tab [rtt_pkg::MAX_RUNS];
    logic [47:0] size_tab   [rtt_pkg::MAX_RUNS];
    int unsigned used;
    xlat_word_t  pending_q[$];
    int errors, printed, commands, words, pieces, empties, drops;

    function new();
        used = 0;
        errors = 0;
        printed = 0;
        commands = 0;
        words = 0;
        pieces = 0;
        empties = 0;
        drops = 0;
    endfunction

    function void queue_word(xlat_word_t w);
        pending_q.insert(pending_q.size(), w);
    endfunction

    function xlat_word_t plain_word(logic full);
        xlat_word_t w;
        w.hit = 1'b0;
        w.member = '0;
        w.ofs = '0;
        w.len = '0;
        w.last = 1'b1;
        w.count = 5'(used);
        w.full = full;
        return w;
    endfunction

    // Works out the result words of one accepted command and updates the table copy.
    function void note_command(logic [2:0] kind, logic [47:0] ioff, logic [7:0] midx,
                               logic [47:0] moff, logic [47:0] len);
        xlat_word_t  w, prev;
        logic        have_prev;
        logic [63:0] qs, qe, rs, re, from, upto, ofs, span;
        int unsigned keep;
        int          n;
        commands++;
        case (kind)
            rtt_pkg::KIND_APPEND: begin
                if (used < rtt_pkg::MAX_RUNS) begin
                    inner_tab[used] = ioff;
                    member_tab[used] = midx;
                    mstart_tab[used] = moff;
                    size_tab[used] = len;
                    used++;
                    queue_word(plain_word(1'b0));
                end else begin
                    drops++;
                    queue_word(plain_word(1'b1));
                end
            end
            rtt_pkg::KIND_CLEAR: begin
                used = 0;
                queue_word(plain_word(1'b0));
            end
            rtt_pkg::KIND_EXCLUDE: begin
                keep = 0;
                for (int i = 0; i < used; i++) begin
                    if (member_tab[i] != midx) begin
                        inner_tab[keep] = inner_tab[i];
                        member_tab[keep] = member_tab[i];
                        mstart_tab[keep] = mstart_tab[i];
                        size_tab[keep] = size_tab[i];
                        keep++;
                    end
                end
                used = keep;
                queue_word(plain_word(1'b0));
            end
            rtt_pkg::KIND_INNER, rtt_pkg::KIND_MEMBER: begin
                qs = (kind == rtt_pkg::KIND_INNER) ? {16'h0, ioff} : {16'h0, moff};
                qe = qs + {16'h0, len};
                n = 0;
                have_prev = 1'b0;
                for (int i = 0; i < used && n < rtt_pkg::OUT_LIMIT; i++) begin
                    if (kind == rtt_pkg::KIND_MEMBER && member_tab[i] != midx) continue;
                    rs = (kind == rtt_pkg::KIND_INNER) ? {16'h0, inner_tab[i]}
                                                       : {16'h0, mstart_tab[i]};
                    re = rs + {16'h0, size_tab[i]};
                    from = (qs > rs) ? qs : rs;
                    upto = (qe < re) ? qe : re;
                    if (from >= upto) continue;
                    ofs = (kind == rtt_pkg::KIND_INNER) ? {16'h0, mstart_tab[i]}
                                                        : {16'h0, inner_tab[i]};
                    ofs = ofs + (from - rs);
                    span = upto - from;
                    w.hit = 1'b1;
                    w.member = member_tab[i];
                    w.ofs = ofs[48:0];
                    w.len = span[47:0];
                    w.last = 1'b0;
                    w.count = 5'(used);
                    w.full = 1'b0;
                    // The newest piece is held back so that the final one can carry last.
                    if (have_prev) queue_word(prev);
                    prev = w;
                    have_prev = 1'b1;
                    n++;
                end
                if (have_prev) begin
                    prev.last = 1'b1;
                    queue_word(prev);
                end else begin
                    empties++;
                    queue_word(plain_word(1'b0));
                end
            end
            default: queue_word(plain_word(1'b0));
        endcase
    endfunction

    task report(string field, logic [63:0] got, logic [63:0] want);
        errors++;
        if (printed < 40) begin
            printed++;
            $display("MISMATCH at %0t on %s: got %h, expected %h", $time, field, got, want);
        end
    endtask

    task check_word(xlat_word_t got);
        xlat_word_t want;
        words++;
        if (got.hit === 1'b1) pieces++;
        if (pending_q.size() == 0) begin
            report("result word with nothing pending", 64'(got.len), 64'h0);
            return;
        end
        want = pending_q.pop_front();
        if (got.hit !== want.hit) report("hit", 64'(got.hit), 64'(want.hit));
        if (got.member !== want.member) report("piece_member", 64'(got.member), 64'(want.member));
        if (got.ofs !== want.ofs) report("piece_offset", 64'(got.ofs), 64'(want.ofs));
        if (got.len !== want.len) report("piece_length", 64'(got.len), 64'(want.len));
        if (got.last !== want.last) report("last", 64'(got.last), 64'(want.last));
        if (got.count !== want.count) report("run_count", 64'(got.count), 64'(want.count));
        if (got.full !== want.full) report("table_full", 64'(got.full), 64'(want.full));
    endtask
endclass

module run_table_range_translator_tb;
    localparam int WATCHDOG_CYCLES = 3000;
    localparam int RX_HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES    = 40;
    localparam int N_RANDOM        = 80;
    localparam logic [47:0] OFS_MAX = '1;
    localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_s_tvalid = 1'b0;
    logic                            o_s_tready;
    logic [rtt_pkg::IN_DATA_W-1:0]   i_s_tdata = '0;
    logic [rtt_pkg::IN_USER_W-1:0]   i_s_tuser = '0;
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    logic [rtt_pkg::OUT_DATA_W-1:0]  o_m_tdata;
    logic [rtt_pkg::OUT_USER_W-1:0]  o_m_tuser;
    logic                            o_m_tlast;

    xlat_scoreboard sb;
    logic tx_quiet = 1'b0;
    logic rx_quiet = 1'b0;
    logic rx_hold_req = 1'b0;
    logic rx_hold_done = 1'b0;
    int   rx_hold_cnt = 0;
    int   stuck_cycles = 0;

    // Sequence state used to shape well-formed random tables.
    logic [47:0] seq_base, inner_cur;
    logic [7:0]  pool [4];
    logic [47:0] mbase [4];
    logic [47:0] mcur [4];

    run_table_range_translator DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [47:0] rand48();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[47:0];
    endfunction

    function automatic logic [47:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 16) return rand48();
        if (r < 19) return OFS_MAX;
        return 48'($urandom_range(1, 200));
    endfunction

    // Sends one command word and returns once it has been accepted.
    task send_cmd(input logic [2:0] kind, input logic [47:0] ioff, input logic [7:0] midx,
                  input logic [47:0] moff, input logic [47:0] len);
        while (!tx_quiet && $urandom_range(0, 99) < 36) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= kind;
        i_s_tdata <= {len, moff, midx, ioff};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_command(kind, ioff, midx, moff, len);
    endtask

    task start_sequence();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0) seq_base = '0;
        else if (r == 1) seq_base = OFS_MAX - 48'($urandom_range(0, 600));
        else seq_base = rand48();
        inner_cur = seq_base;
        for (int k = 0; k < 4; k++) begin
            pool[k] = (k == 0 && r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
            mbase[k] = ($urandom_range(0, 3) == 0) ? '0 : rand48();
            mcur[k] = mbase[k];
        end
    endtask

    task append_in_sequence();
        int p;
        logic [47:0] len_v;
        p = $urandom_range(0, 3);
        len_v = pick_len();
        if ($urandom_range(0, 4) == 0) begin
            // Run placed up to 300 past the sequence base, so it may overlap runs laid out so far.
            send_cmd(rtt_pkg::KIND_APPEND, seq_base + 48'($urandom_range(0, 300)), pool[p],
                     mcur[p], len_v);
        end else begin
            send_cmd(rtt_pkg::KIND_APPEND, inner_cur, pool[p], mcur[p], len_v);
            inner_cur = inner_cur + len_v;
        end
        mcur[p] = mcur[p] + len_v;
    endtask

    // Receiver: random back-pressure, a quiet stretch, and one long hold-off.
    always @(posedge i_clk) begin
        if (rx_hold_req && !rx_hold_done) begin
            i_m_tready <= 1'b0;
            rx_hold_cnt <= rx_hold_cnt + 1;
            if (rx_hold_cnt == RX_HOLD_CYCLES - 1) rx_hold_done <= 1'b1;
        end else if (rx_quiet) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= 36);
        end
    end

    always @(posedge i_clk) begin
        xlat_word_t got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.member = o_m_tdata[7:0];
            got.ofs = o_m_tdata[56:8];
            got.len = o_m_tdata[104:57];
            got.count = o_m_tdata[109:105];
            got.hit = o_m_tuser[0];
            got.full = o_m_tuser[1];
            got.last = o_m_tlast;
            sb.check_word(got);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                stuck_cycles <= 0;
            end else if (stuck_cycles >= WATCHDOG_CYCLES) begin
                $display("Timeout: no word moved for %0d cycles", WATCHDOG_CYCLES);
                $display("Simulation FAILED");
                $finish;
            end else begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    initial begin
        int r, p, n_rand;
        logic [2:0] k;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty table, extreme values, every kind, full table.
        send_cmd(rtt_pkg::KIND_INNER, '0, 8'h00, '0, OFS_MAX);
        send_cmd(rtt_pkg::KIND_APPEND, '0, 8'h00, '0, '0);
        send_cmd(rtt_pkg::KIND_APPEND, 48'd100, 8'h01, 48'd1000, 48'd50);
        send_cmd(rtt_pkg::KIND_APPEND, 48'd150, 8'h02, 48'd0, 48'd100);
        send_cmd(rtt_pkg::KIND_APPEND, 48'd250, 8'h01, 48'd1050, 48'd30);
        send_cmd(rtt_pkg::KIND_APPEND, OFS_MAX, 8'hFF, OFS_MAX, OFS_MAX);
        send_cmd(rtt_pkg::KIND_INNER, '0, 8'h00, '0, OFS_MAX);
        send_cmd(rtt_pkg::KIND_INNER, OFS_MAX, 8'h00, '0, OFS_MAX);
        send_cmd(rtt_pkg::KIND_INNER, 48'd120, 8'h00, '0, '0);
        send_cmd(rtt_pkg::KIND_INNER, 48'd120, 8'h00, '0, 48'd100);
        send_cmd(rtt_pkg::KIND_MEMBER, '0, 8'h01, 48'd1010, 48'd60);
        send_cmd(rtt_pkg::KIND_MEMBER, '0, 8'hFF, OFS_MAX - 48'd5, 48'd10);
        send_cmd(rtt_pkg::KIND_MEMBER, OFS_MAX, 8'h03, '0, OFS_MAX);
        for (int s = KIND_SPARE_FIRST; s <= KIND_SPARE_LAST; s++)
            send_cmd(3'(s), OFS_MAX, 8'hFF, OFS_MAX, OFS_MAX);
        send_cmd(rtt_pkg::KIND_EXCLUDE, '0, 8'h01, '0, '0);
        send_cmd(rtt_pkg::KIND_INNER, '0, 8'h00, '0, OFS_MAX);
        send_cmd(rtt_pkg::KIND_CLEAR, OFS_MAX, 8'hFF, OFS_MAX, OFS_MAX);
        // Sixteen overlapping runs give the longest answer, then one append too many.
        for (int i = 0; i < rtt_pkg::MAX_RUNS; i++)
            send_cmd(rtt_pkg::KIND_APPEND, 48'(i * 8), 8'(i), rand48(), 48'd64);
        send_cmd(rtt_pkg::KIND_APPEND, 48'd5, 8'h11, 48'd5, 48'd5);
        send_cmd(rtt_pkg::KIND_INNER, '0, 8'h00, '0, 48'd300);
        send_cmd(rtt_pkg::KIND_EXCLUDE, '0, 8'hAA, '0, '0);
        send_cmd(rtt_pkg::KIND_CLEAR, '0, 8'h00, '0, '0);
        send_cmd(rtt_pkg::KIND_MEMBER, '0, 8'h00, '0, OFS_MAX);

        // Random part: mostly tables built from well-formed runs, queried around their span.
        start_sequence();
        n_rand = 0;
        while (n_rand < N_RANDOM) begin
            if (n_rand >= 30) rx_hold_req = 1'b1;
            tx_quiet = (n_rand >= 50 && n_rand < 70);
            rx_quiet = tx_quiet;
            r = $urandom_range(0, 99);
            p = $urandom_range(0, 3);
            if (r < 8) begin
                send_cmd(rtt_pkg::KIND_CLEAR, rand48(), 8'($urandom_range(0, 255)), rand48(),
                         rand48());
                start_sequence();
            end else if (r < 38) begin
                append_in_sequence();
            end else if (r < 58) begin
                send_cmd(rtt_pkg::KIND_INNER,
                         ($urandom_range(0, 4) == 0) ? rand48()
                                                     : seq_base + 48'($urandom_range(0, 300)),
                         8'($urandom_range(0, 255)), rand48(), pick_len());
            end else if (r < 76) begin
                send_cmd(rtt_pkg::KIND_MEMBER, rand48(),
                         ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) : pool[p],
                         mbase[p] + 48'($urandom_range(0, 250)), pick_len());
            end else if (r < 83) begin
                send_cmd(rtt_pkg::KIND_EXCLUDE, rand48(), pool[p], rand48(), rand48());
            end else if (r < 86) begin
                while (sb.used < rtt_pkg::MAX_RUNS) begin
                    append_in_sequence();
                    n_rand++;
                end
                append_in_sequence();
            end else if (r < 93) begin
                k = 3'($urandom_range(0, 7));
                send_cmd(k, rand48(), 8'($urandom_range(0, 255)), rand48(), rand48());
            end else begin
                send_cmd(rtt_pkg::KIND_INNER, seq_base, 8'h00, '0, OFS_MAX);
            end
            n_rand++;
        end
        i_s_tvalid <= 1'b0;
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;

        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending_q.size() != 0)
            sb.report("words never produced", 64'(sb.pending_q.size()), 64'h0);

        $display("Covered %0d commands and %0d result words: %0d pieces, %0d empty answers,",
                 sb.commands, sb.words, sb.pieces, sb.empties);
        $display("%0d dropped appends; receiver hold-off of %0d cycles %0s; %0d mismatches.",
                 sb.drops, RX_HOLD_CYCLES, rx_hold_done ? "done" : "not reached", sb.errors);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
